FILE: hw/rtl/kli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_pkg
// shared constants and codes for the keyframe linear interpolator
// ----------------------------------------------------------------------------
package kli_pkg;
	localparam int unsigned KEYS_DEF = 64;
	localparam int unsigned VW = 32;
	localparam int unsigned FRAC = 30;

	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_ADVANCE = 2'd1,
		FN_RESET = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INTERP = 3'd0,
		ST_FIRST = 3'd1,
		ST_LAST = 3'd2,
		ST_EMPTY = 3'd3,
		ST_ZERO = 3'd4
	} status_t;
endpackage

FILE: hw/rtl/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top
// one animation track of keys, sampled by linear interpolation
// ----------------------------------------------------------------------------
// s_axis carries items: func in tuser, other fields packed in tdata.
// a load transfer writes one key slot. a reset transfer clears the play time.
// an advance transfer adds time_step (saturating), wraps the play time modulo
// the last key time with a bit-serial remainder, walks the key table from the
// top to find the segment, forms the fraction with a bit-serial divider and
// mixes each component with a 2-bit-per-cycle multiply; on an empty track it
// returns zeros, and at or beyond an end key it holds that key's values.
// m_axis carries one result per advance from an output register; a new item
// is taken only once the result register is empty, so a stalled receiver
// holds the block with the result unchanged.
// reset clears the play time, key_count, the state, the output valid flag,
// the read address and the counters; key slots stay undefined until written.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top
	import kli_pkg::*;
#(
	parameter int unsigned KEYS = KEYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// key_index[5:0], key_time, key_x, key_y, key_z, time_step, zero pad
	input  logic [167:0] s_axis_tdata,
	// func
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x, out_y, out_z, segment[5:0], sample_time, zero pad
	output logic [135:0] m_axis_tdata,
	// status
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	localparam int unsigned AW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int unsigned CW = AW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RDLAST, S_MOD, S_RD0, S_SRCH, S_RDSEG, S_DIV,
		S_MUL, S_HOLD, S_DONE
	} state_t;

	state_t state_q;
	logic [VW-1:0] t_mem [KEYS];
	logic [VW-1:0] x_mem [KEYS];
	logic [VW-1:0] y_mem [KEYS];
	logic [VW-1:0] z_mem [KEYS];

	logic [6:0] key_count_q;
	logic [VW-1:0] play_q;
	logic [AW-1:0] raddr_q;
	logic [VW-1:0] rt_q, rx_q, ry_q, rz_q;
	logic [AW-1:0] last_q, idx_q;
	logic [VW-1:0] tlast_q, tfirst_q, t1_q;
	logic [VW:0] rem_q;
	logic [VW-1:0] quo_q, div_q;
	logic [5:0] cnt_q;
	logic [1:0] comp_q, rdph_q;
	logic [VW-1:0] a_q [3];
	logic [VW-1:0] b_q [3];
	logic [VW:0] diff_q;
	logic [FRAC:0] f_q, fsh_q;
	logic signed [VW+FRAC+3:0] acc_q;
	logic [VW-1:0] ox_q, oy_q, oz_q;
	logic [AW-1:0] seg_q;
	status_t st_q;
	logic ovalid_q;

	logic [6:0] n_cap;
	logic [167:0] d;
	assign d = s_axis_tdata;
	assign n_cap = (32'(key_count_q) > KEYS) ? 7'(KEYS) : key_count_q;

	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;

	// memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_LOAD &&
			32'(d[5:0]) < KEYS) begin
			t_mem[AW'(d[5:0])] <= d[37:6];
			x_mem[AW'(d[5:0])] <= d[69:38];
			y_mem[AW'(d[5:0])] <= d[101:70];
			z_mem[AW'(d[5:0])] <= d[133:102];
		end
		rt_q <= t_mem[raddr_q];
		rx_q <= x_mem[raddr_q];
		ry_q <= y_mem[raddr_q];
		rz_q <= z_mem[raddr_q];
	end

	// next-step signals
	logic [VW:0] rem_sh;
	logic [VW:0] sum;
	logic signed [VW+FRAC+3:0] pp;
	logic signed [VW+1:0] dsx;
	logic hit;
	logic [VW-1:0] tdiff;
	assign rem_sh = {rem_q[VW-1:0], quo_q[VW-1]};
	assign sum = {1'b0, play_q} + {1'b0, d[165:134]};
	assign dsx = {diff_q[VW], diff_q};
	assign hit = (play_q >= rt_q) && (play_q <= t1_q);
	assign tdiff = play_q - tfirst_q;
	always_comb begin
		pp = '0;
		case (fsh_q[1:0])
			2'd1: pp = (VW+FRAC+4)'(dsx);
			2'd2: pp = (VW+FRAC+4)'(dsx) <<< 1;
			2'd3: pp = (VW+FRAC+4)'(dsx) + ((VW+FRAC+4)'(dsx) <<< 1);
			default: pp = '0;
		endcase
	end

	logic signed [VW+FRAC+3:0] rnd;
	assign rnd = acc_q + (VW+FRAC+4)'(64'sd1 <<< (FRAC-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_count_q <= '0;
			play_q <= '0;
			ovalid_q <= 1'b0;
			raddr_q <= '0;
			cnt_q <= '0;
			comp_q <= '0;
			rdph_q <= '0;
		end else begin
			if (cfg_we)
				key_count_q <= cfg_wdata;
			if (ovalid_q && m_axis_tready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						if (s_axis_tuser == FN_RESET)
							play_q <= '0;
						else if (s_axis_tuser == FN_ADVANCE) begin
							play_q <= sum[VW] ? '1 : sum[VW-1:0];
							if (n_cap == 0) begin
								ox_q <= '0; oy_q <= '0; oz_q <= '0;
								seg_q <= '0; st_q <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								last_q <= AW'(n_cap - 7'd1);
								raddr_q <= AW'(n_cap - 7'd1);
								rdph_q <= '0;
								state_q <= S_RDLAST;
							end
						end
					end
				end
				S_RDLAST: begin
					// wait for the registered read of the last key
					if (rdph_q == 2'd1) begin
						tlast_q <= rt_q;
						if (play_q > rt_q) begin
							if (rt_q == 0) begin
								play_q <= '0;
								raddr_q <= '0;
								rdph_q <= '0;
								state_q <= S_RD0;
							end else begin
								rem_q <= '0;
								quo_q <= play_q;
								div_q <= rt_q;
								cnt_q <= '0;
								state_q <= S_MOD;
							end
						end else begin
							raddr_q <= '0;
							rdph_q <= '0;
							state_q <= S_RD0;
						end
					end else
						rdph_q <= rdph_q + 2'd1;
				end
				S_MOD: begin
					// restoring remainder, one bit per cycle
					quo_q <= {quo_q[VW-2:0], 1'b0};
					if (rem_sh >= {1'b0, div_q})
						rem_q <= rem_sh - {1'b0, div_q};
					else
						rem_q <= rem_sh;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(VW-1)) begin
						play_q <= (rem_sh >= {1'b0, div_q}) ?
							VW'(rem_sh - {1'b0, div_q}) : rem_sh[VW-1:0];
						raddr_q <= '0;
						rdph_q <= '0;
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					if (rdph_q == 2'd1) begin
						tfirst_q <= rt_q;
						if (play_q <= rt_q) begin
							seg_q <= '0; st_q <= ST_FIRST;
							raddr_q <= '0; rdph_q <= '0;
							state_q <= S_HOLD;
						end else if (play_q >= tlast_q) begin
							seg_q <= last_q; st_q <= ST_LAST;
							raddr_q <= last_q; rdph_q <= '0;
							state_q <= S_HOLD;
						end else begin
							// walk down from the last key: the lowest matching i wins
							seg_q <= last_q; st_q <= ST_LAST;
							idx_q <= last_q;
							t1_q <= tlast_q;
							raddr_q <= last_q - AW'(1);
							rdph_q <= '0;
							state_q <= S_SRCH;
						end
					end else
						rdph_q <= rdph_q + 2'd1;
				end
				S_SRCH: begin
					if (rdph_q == 2'd1) begin
						rdph_q <= '0;
						// rt_q is key idx-1, t1_q is key idx
						if (hit) begin
							seg_q <= idx_q - AW'(1);
							st_q <= (t1_q == rt_q) ? ST_ZERO : ST_INTERP;
						end
						t1_q <= rt_q;
						idx_q <= idx_q - AW'(1);
						if (idx_q == AW'(1)) begin
							raddr_q <= hit ? idx_q - AW'(1) : seg_q;
							state_q <= S_RDSEG;
						end else
							raddr_q <= idx_q - AW'(2);
					end else
						rdph_q <= rdph_q + 2'd1;
				end
				S_RDSEG: begin
					// seg_q already final; fetch lower then upper key
					if (st_q != ST_INTERP) begin
						raddr_q <= seg_q;
						rdph_q <= '0;
						state_q <= S_HOLD;
					end else if (rdph_q == 2'd0) begin
						raddr_q <= seg_q + AW'(1);
						rdph_q <= rdph_q + 2'd1;
					end else if (rdph_q == 2'd1) begin
						a_q[0] <= rx_q; a_q[1] <= ry_q; a_q[2] <= rz_q;
						tfirst_q <= rt_q;
						rdph_q <= rdph_q + 2'd1;
					end else begin
						b_q[0] <= rx_q; b_q[1] <= ry_q; b_q[2] <= rz_q;
						div_q <= rt_q - tfirst_q;
						// (t-t0)<<30: upper bits preloaded, low bit then zeros shifted in
						rem_q <= {2'b0, tdiff[VW-1:1]};
						quo_q <= {tdiff[0], {(VW-1){1'b0}}};
						cnt_q <= '0;
						f_q <= '0;
						rdph_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// fraction (t-t0)<<30 / d, one quotient bit per cycle
					quo_q <= {quo_q[VW-2:0], 1'b0};
					if (rem_sh >= {1'b0, div_q}) begin
						rem_q <= rem_sh - {1'b0, div_q};
						f_q <= {f_q[FRAC-1:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						f_q <= {f_q[FRAC-1:0], 1'b0};
					end
					if (cnt_q == 6'(VW+FRAC-VW)) begin
						comp_q <= '0;
						cnt_q <= '0;
						state_q <= S_MUL;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_MUL: begin
					if (cnt_q == 6'd0) begin
						diff_q <= {b_q[comp_q][VW-1], b_q[comp_q]}
							- {a_q[comp_q][VW-1], a_q[comp_q]};
						fsh_q <= f_q;
						acc_q <= '0;
						cnt_q <= 6'd1;
					end else if (cnt_q <= 6'd16) begin
						acc_q <= acc_q + (pp <<< (2 * (cnt_q - 6'd1)));
						fsh_q <= fsh_q >> 2;
						cnt_q <= cnt_q + 6'd1;
					end else begin
						case (comp_q)
							2'd0: ox_q <= a_q[0] + VW'(rnd >>> FRAC);
							2'd1: oy_q <= a_q[1] + VW'(rnd >>> FRAC);
							default: oz_q <= a_q[2] + VW'(rnd >>> FRAC);
						endcase
						cnt_q <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2)
							state_q <= S_DONE;
					end
				end
				S_HOLD: begin
					if (rdph_q == 2'd1) begin
						ox_q <= rx_q; oy_q <= ry_q; oz_q <= rz_q;
						state_q <= S_DONE;
					end else
						rdph_q <= rdph_q + 2'd1;
				end
				S_DONE: begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b0, play_q, 6'(seg_q), oz_q, oy_q, ox_q};
	assign m_axis_tuser = st_q;

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE && !ovalid_q)
		else $error("ready outside idle");
	ap_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> ovalid_q)
		else $error("result lost");
endmodule
